### rtl/ims_pkg.sv
// Shared constants and codes for the integer multiset table.
// No dependencies.
package ims_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_MEMBER = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_KEEP   = 3'd3,
    ACT_DEDUP  = 3'd4,
    ACT_READ   = 3'd5,
    ACT_WRITE  = 3'd6
  } action_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

### rtl/integer_multiset_table.sv
// Integer multiset table: ordered value table in one synchronous memory.
// Depends on ims_pkg.
// Member test, erase and keep first scan all stored entries through the single
// memory read port; remove repeats compares each entry with those kept so far.
// One item in flight; the next is taken once a result sits in the output
// register. Reset: synchronous, clears count and control; memory undefined.
module integer_multiset_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [31:0] value,
  input  logic [5:0]  index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_member,
  output logic [31:0] read_value,
  output logic [6:0]  element_count,
  output logic [1:0]  status
);
  import ims_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_RFETCH = 7'b0000100,
    S_RLOAD  = 7'b0001000,
    S_RCMP   = 7'b0010000,
    S_RDWAIT = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state;

  logic [31:0] mem [CAPACITY];
  logic [31:0] mem_q;
  logic        rd_en, we;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] wdata;

  logic [CW-1:0] cnt, ra, wr, rd;
  logic [2:0]  op;
  logic [31:0] val_q, e_reg;
  logic        pv, seen, dup;
  logic        res_member;
  logic [31:0] res_rdata;
  logic [1:0]  res_status;

  logic acc, in_range, not_full, issue_scan, issue_cmp, hit, dup_hit, keep_it;

  assign in_stall   = (state != S_IDLE);
  assign acc        = in_valid && !in_stall;
  assign in_range   = {1'b0, index} < cnt;
  assign not_full   = cnt < CW'(CAPACITY);
  assign issue_scan = ra < cnt;
  assign issue_cmp  = ra < wr;
  assign hit        = mem_q == val_q;
  assign dup_hit    = mem_q == e_reg;
  assign keep_it    = !hit || ((op == ACT_KEEP) && !seen);

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = value;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (action == ACT_READ && in_range) begin
            rd_en = 1'b1;
            raddr = index[AW-1:0];
          end
          if (action == ACT_APPEND && not_full) begin
            we    = 1'b1;
            waddr = cnt[AW-1:0];
          end
          if (action == ACT_WRITE && in_range) begin
            we    = 1'b1;
            waddr = index[AW-1:0];
          end
        end
      end
      S_SCAN: begin
        rd_en = issue_scan;
        raddr = ra[AW-1:0];
        if (pv && op != ACT_MEMBER && keep_it) begin
          we    = 1'b1;
          waddr = wr[AW-1:0];
          wdata = mem_q;
        end
      end
      S_RFETCH: begin
        rd_en = rd < cnt;
        raddr = rd[AW-1:0];
      end
      S_RCMP: begin
        rd_en = issue_cmp;
        raddr = ra[AW-1:0];
        if (!issue_cmp && !pv && !dup) begin
          we    = 1'b1;
          waddr = wr[AW-1:0];
          wdata = e_reg;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      ra        <= '0;
      wr        <= '0;
      rd        <= '0;
      pv        <= 1'b0;
      seen      <= 1'b0;
      dup       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            op         <= action;
            val_q      <= value;
            res_member <= 1'b0;
            res_rdata  <= '0;
            res_status <= ST_OK;
            ra         <= '0;
            wr         <= '0;
            rd         <= '0;
            pv         <= 1'b0;
            seen       <= 1'b0;
            state      <= S_FIN;
            case (action)
              ACT_APPEND: begin
                if (not_full) cnt <= cnt + 1'b1;
                else res_status <= ST_FULL;
              end
              ACT_MEMBER, ACT_ERASE, ACT_KEEP: state <= S_SCAN;
              ACT_DEDUP: state <= S_RFETCH;
              ACT_READ: begin
                if (in_range) state <= S_RDWAIT;
                else res_status <= ST_RANGE;
              end
              ACT_WRITE: begin
                if (!in_range) res_status <= ST_RANGE;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (issue_scan) ra <= ra + 1'b1;
          pv <= issue_scan;
          if (pv) begin
            if (hit) begin
              res_member <= (op == ACT_MEMBER);
              seen       <= 1'b1;
            end
            if (op != ACT_MEMBER && keep_it) wr <= wr + 1'b1;
          end
          if (!issue_scan && !pv) begin
            if (op != ACT_MEMBER) cnt <= wr;
            state <= S_FIN;
          end
        end
        S_RFETCH: begin
          if (rd < cnt) state <= S_RLOAD;
          else begin
            cnt   <= wr;
            state <= S_FIN;
          end
        end
        S_RLOAD: begin
          e_reg <= mem_q;
          ra    <= '0;
          pv    <= 1'b0;
          dup   <= 1'b0;
          state <= S_RCMP;
        end
        S_RCMP: begin
          if (issue_cmp) ra <= ra + 1'b1;
          pv <= issue_cmp;
          if (pv && dup_hit) dup <= 1'b1;
          if (!issue_cmp && !pv) begin
            if (!dup) wr <= wr + 1'b1;
            rd    <= rd + 1'b1;
            state <= S_RFETCH;
          end
        end
        S_RDWAIT: begin
          res_rdata <= mem_q;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            is_member     <= res_member;
            read_value    <= res_rdata;
            element_count <= cnt;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY)) else $error("count above capacity");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> element_count == CW'(CAPACITY))
    else $error("full status with free space");

  a_member_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_member |-> status == ST_OK && read_value == '0)
    else $error("member flag with bad status or data");

endmodule
